// ===== sv/skmw_pkg.sv =====
// ----------------------------------------------------------------------------
// skmw_pkg
// Shared types and constants for the sparse key maximum weight core.
// ----------------------------------------------------------------------------
package skmw_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int KEY_W           = 64;
	localparam int WEIGHT_W        = 32;
	localparam int SLOT_W          = 6;
	localparam int COUNT_W         = 7;
	localparam int CMD_W           = 2;
	localparam int IN_DATA_W       = 168;
	localparam int OUT_DATA_W      = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_ELEMENT = 2'd1,
		CMD_EMPTY   = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] max_weight;
		logic                any_match;
	} result_t;

endpackage

// ===== sv/skmw_match.sv =====
// ----------------------------------------------------------------------------
// skmw_match
// Query key store with a parallel compare against one element key and a
// lowest-index-first priority encoder over the active entries.
// ----------------------------------------------------------------------------
module skmw_match #(
	parameter int TABLE_DEPTH = skmw_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [IDX_W-1:0]             wr_idx,
	input  logic [skmw_pkg::KEY_W-1:0]   wr_key,
	input  logic [skmw_pkg::COUNT_W-1:0] entries_in_use,
	input  logic [skmw_pkg::KEY_W-1:0]   key,
	output logic                         hit,
	output logic [IDX_W-1:0]             hit_idx
);
	import skmw_pkg::*;

	logic [KEY_W-1:0]       key_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q[wr_idx] <= wr_key;
		end
	end

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = (key_q[i] == key) && (int'(entries_in_use) > i);
		end
	end

	// lowest matching index wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

endmodule

// ===== sv/sparse_key_max_weight_core.sv =====
// A request passes the input register, stage 2 and the output queue before its result shows on m_tvalid.
// Throughput: one request per cycle while the output queue has room, set by the parallel key compare.
// A two-entry output queue lets requests flow while one result waits.
// Reset clears the pipeline, output queue, running maximum, found flag and
// entries_in_use; key and weight tables hold nothing valid until loaded.
// ----------------------------------------------------------------------------
// sparse_key_max_weight_core
// Matches streamed document keys against a loaded query table and reports
// the largest matched weight per document.
// ----------------------------------------------------------------------------
module sparse_key_max_weight_core #(
	parameter int TABLE_DEPTH = skmw_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: entries_in_use
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [skmw_pkg::COUNT_W-1:0]    cfg_data,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// entry_index, entry_key, entry_weight, element_key (2 pad bits on top)
	input  logic [skmw_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [skmw_pkg::CMD_W-1:0]      s_tuser,
	input  logic                            s_tlast,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// max_weight
	output logic [skmw_pkg::OUT_DATA_W-1:0] m_tdata,
	// any_match
	output logic                            m_tuser
);
	import skmw_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [COUNT_W-1:0]  entries_q;

	logic                pipe_en;

	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [KEY_W-1:0]    entry_key_s1;
	logic [WEIGHT_W-1:0] entry_weight_s1;
	logic [KEY_W-1:0]    element_key_s1;
	logic                last_s1;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic                hit;
	logic [IDX_W-1:0]    hit_idx;

	logic [WEIGHT_W-1:0] weight_mem [TABLE_DEPTH];

	logic                valid_s2;
	cmd_t                cmd_s2;
	logic                last_s2;
	logic                hit_s2;
	logic [WEIGHT_W-1:0] weight_s2;

	logic [WEIGHT_W-1:0] run_max_q, run_max_d;
	logic                seen_q, seen_d;
	logic                push;
	result_t             res;

	logic [1:0]          count_q;
	result_t             head_q, skid_q;
	logic                pop;
	logic                push_en;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg_valid) begin
			entries_q <= cfg_data;
		end
	end

	// pipeline advances while the output queue has room
	assign pipe_en  = (count_q != 2'd2);
	assign s_tready = pipe_en;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pipe_en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en && s_tvalid) begin
			cmd_s1          <= cmd_t'(s_tuser);
			slot_s1         <= s_tdata[5:0];
			entry_key_s1    <= s_tdata[69:6];
			entry_weight_s1 <= s_tdata[101:70];
			element_key_s1  <= s_tdata[165:102];
			last_s1         <= s_tlast;
		end
	end

	assign wr_en  = pipe_en && valid_s1 && (cmd_s1 == CMD_LOAD)
		&& (int'(slot_s1) < TABLE_DEPTH);
	assign wr_idx = IDX_W'(slot_s1);

	skmw_match #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_match (
		.clk            (clk),
		.wr_en          (wr_en),
		.wr_idx         (wr_idx),
		.wr_key         (entry_key_s1),
		.entries_in_use (entries_q),
		.key            (element_key_s1),
		.hit            (hit),
		.hit_idx        (hit_idx)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			weight_mem[wr_idx] <= entry_weight_s1;
		end
		if (pipe_en) begin
			weight_s2 <= weight_mem[hit_idx];
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pipe_en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			cmd_s2  <= cmd_s1;
			last_s2 <= last_s1;
			hit_s2  <= hit && (cmd_s1 == CMD_ELEMENT);
		end
	end

	always_comb begin
		run_max_d = run_max_q;
		seen_d    = seen_q;
		push      = 1'b0;
		res       = '0;
		if (valid_s2) begin
			unique case (cmd_s2)
				CMD_EMPTY: begin
					run_max_d = '0;
					seen_d    = 1'b0;
					push      = 1'b1;
				end
				CMD_ELEMENT: begin
					if (hit_s2 && (!seen_q || ($signed(weight_s2) > $signed(run_max_q)))) begin
						run_max_d = weight_s2;
					end
					if (hit_s2) begin
						seen_d = 1'b1;
					end
					if (last_s2) begin
						push           = 1'b1;
						res.max_weight = seen_d ? run_max_d : '0;
						res.any_match  = seen_d;
						run_max_d      = '0;
						seen_d         = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_max_q <= '0;
			seen_q    <= 1'b0;
		end else if (pipe_en) begin
			run_max_q <= run_max_d;
			seen_q    <= seen_d;
		end
	end

	// output queue: head plus skid entry
	assign push_en  = push && pipe_en;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (count_q != 2'd0);
	assign m_tdata  = head_q.max_weight;
	assign m_tuser  = head_q.any_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			unique case ({push_en, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push_en, pop})
			2'b10: begin
				if (count_q == 2'd0) begin
					head_q <= res;
				end else begin
					skid_q <= res;
				end
			end
			2'b01: begin
				head_q <= skid_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					head_q <= res;
				end else begin
					head_q <= skid_q;
					skid_q <= res;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/sparse_key_max_weight_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_key_max_weight_core_tb
// Loads a query table of keys and weights, then streams documents of keys
// through the core. A clocked driver and monitor, with random gaps and
// stalls on both sides, check every max weight and found flag against an
// in-bench tracker of the table and of each document's running maximum.
// ----------------------------------------------------------------------------
module sparse_key_max_weight_core_tb;

	import skmw_pkg::*;

	localparam int                TABLE_SLOTS = TABLE_DEPTH_DEF;
	localparam int                CYCLE_LIMIT = 500000;
	localparam int                DRAIN_WAIT  = 10;
	localparam int                RANDOM_REQS = 1050;
	localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
	localparam logic [KEY_W-1:0]  KEY_MIN     = 64'h8000_0000_0000_0000;
	localparam logic [KEY_W-1:0]  KEY_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [WEIGHT_W-1:0] WT_MIN    = 32'h8000_0000;
	localparam logic [WEIGHT_W-1:0] WT_MAX    = 32'h7FFF_FFFF;

	typedef struct {
		logic [CMD_W-1:0]    cmd;
		logic [SLOT_W-1:0]   slot;
		logic [KEY_W-1:0]    slot_key;
		logic [WEIGHT_W-1:0] slot_weight;
		logic [KEY_W-1:0]    doc_key;
		logic                last;
	} doc_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [COUNT_W-1:0]    cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// entry_index, entry_key, entry_weight, element_key, zero pad
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// cmd
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// max_weight
	logic [OUT_DATA_W-1:0] m_tdata;
	// any_match
	logic                  m_tuser;

	sparse_key_max_weight_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// tracked copy of the core
	logic [KEY_W-1:0]    trk_key [TABLE_SLOTS];
	logic [WEIGHT_W-1:0] trk_weight [TABLE_SLOTS];
	logic [WEIGHT_W-1:0] doc_max = '0;
	logic                doc_hit = 1'b0;
	logic [COUNT_W-1:0]  active_entries = '0;

	// generator's view of the table, ahead of the core
	logic [KEY_W-1:0]    gen_key [TABLE_SLOTS];

	doc_req_t pending_reqs[$];
	result_t  awaited_results[$];
	doc_req_t cur_req;

	int  errors = 0;
	int  cycles = 0;
	int  results_seen = 0;
	int  send_gap = 0;
	int  recv_stall = 0;
	int  hold_left = 0;
	bit  long_hold_done = 1'b0;
	bit  burst = 1'b0;

	function automatic logic [KEY_W-1:0] rand_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40)
			return {{32{1'b0}}, $urandom} ^ {{32{r[0]}}, 32'h0} |
				{{32{1'b0}}, 32'h0} ^ ({{32{1'b0}}, 32'h0});
		else if (r < 45)
			return r[0] ? KEY_MIN : KEY_MAX;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [WEIGHT_W-1:0] rand_weight();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 4)
			return WT_MIN;
		else if (r < 8)
			return WT_MAX;
		else if (r < 30)
			return $urandom_range(200) - 100;
		return $urandom;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (burst || r < 65)
			return 0;
		else if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic doc_req_t noise_req(logic [CMD_W-1:0] cmd);
		doc_req_t req;
		req.cmd         = cmd;
		req.slot        = SLOT_W'($urandom);
		req.slot_key    = {$urandom, $urandom};
		req.slot_weight = $urandom;
		req.doc_key     = {$urandom, $urandom};
		req.last        = 1'($urandom);
		return req;
	endfunction

	task automatic add_load(input logic [SLOT_W-1:0] slot, input logic [KEY_W-1:0] key,
			input logic [WEIGHT_W-1:0] wt);
		doc_req_t req;
		req             = noise_req(CMD_LOAD);
		req.slot        = slot;
		req.slot_key    = key;
		req.slot_weight = wt;
		gen_key[slot]   = key;
		pending_reqs.push_back(req);
	endtask

	task automatic add_element(input logic [KEY_W-1:0] key, input logic last);
		doc_req_t req;
		req         = noise_req(CMD_ELEMENT);
		req.doc_key = key;
		req.last    = last;
		pending_reqs.push_back(req);
	endtask

	task automatic add_other(input logic [CMD_W-1:0] cmd);
		pending_reqs.push_back(noise_req(cmd));
	endtask

	task automatic track_max_weight(input doc_req_t req);
		int   n;
		result_t res;
		if (req.cmd == CMD_LOAD) begin
			trk_key[req.slot]    = req.slot_key;
			trk_weight[req.slot] = req.slot_weight;
		end else if (req.cmd == CMD_EMPTY) begin
			doc_max = '0;
			doc_hit = 1'b0;
			res.max_weight = '0;
			res.any_match  = 1'b0;
			awaited_results.push_back(res);
		end else if (req.cmd == CMD_ELEMENT) begin
			n = (active_entries > TABLE_SLOTS) ? TABLE_SLOTS : active_entries;
			for (int i = 0; i < n; i++) begin
				if (trk_key[i] == req.doc_key) begin
					if (!doc_hit || $signed(trk_weight[i]) > $signed(doc_max))
						doc_max = trk_weight[i];
					doc_hit = 1'b1;
					break;
				end
			end
			if (req.last) begin
				res.max_weight = doc_hit ? doc_max : '0;
				res.any_match  = doc_hit;
				awaited_results.push_back(res);
				doc_max = '0;
				doc_hit = 1'b0;
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_tvalid || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_entries(input logic [COUNT_W-1:0] value);
		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid      <= 1'b0;
		active_entries = value;
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				track_max_weight(cur_req);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					cur_req  = pending_reqs.pop_front();
					s_tdata  <= {2'b00, cur_req.doc_key, cur_req.slot_weight,
						cur_req.slot_key, cur_req.slot};
					s_tuser  <= cur_req.cmd;
					s_tlast  <= cur_req.last;
					s_tvalid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("unexpected result: max_weight %h any_match %b", m_tdata, m_tuser);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (m_tdata !== want.max_weight) begin
						$error("max_weight: expected %h, got %h", want.max_weight, m_tdata);
						errors++;
					end
					if (m_tuser !== want.any_match) begin
						$error("any_match: expected %b, got %b", want.any_match, m_tuser);
						errors++;
					end
				end
				recv_stall = pick_gap();
			end
			if (!long_hold_done && results_seen >= 60) begin
				long_hold_done = 1'b1;
				hold_left      = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sparse_key_max_weight_core verification failed");
			$finish;
		end
	end

	initial begin
		int          sent;
		int          phase;
		int          phase_reqs;
		int          doc_len;
		int          n_eff;
		int unsigned r;
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] setting;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, then a handful of extreme entries
		write_entries('0);
		add_element(64'd0, 1'b1);
		add_other(CMD_EMPTY);
		add_other(CMD_UNUSED);
		add_load(6'd0, KEY_MIN, WT_MIN);
		add_load(6'd1, KEY_MAX, WT_MAX);
		add_load(6'd2, 64'd0, 32'd0);
		add_load(6'd3, '1, '1);
		add_load(6'd4, KEY_MAX, 32'd5);
		add_load(6'd63, 64'd7, 32'd3);
		write_entries(7'd5);
		// duplicate key: slot 1 must win over slot 4
		add_element(KEY_MAX, 1'b0);
		add_element(KEY_MIN, 1'b1);
		add_element(KEY_MIN, 1'b1);
		add_element(64'd12345, 1'b1);
		// a negative-weight match sets the found flag and a later weight of zero beats it
		add_element('1, 1'b0);
		add_element(64'd0, 1'b1);
		// empty document discards a partial one
		add_element('1, 1'b0);
		add_other(CMD_EMPTY);
		add_element(64'd12345, 1'b1);
		// table rewritten mid-document, running maximum kept
		add_element('1, 1'b0);
		add_load(6'd2, 64'd0, 32'd9);
		add_other(CMD_UNUSED);
		add_element(64'd0, 1'b1);

		// fill the whole table before any wide setting
		wait_idle();
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			r = $urandom_range(9);
			if (r == 0 && i > 0)
				key = gen_key[$urandom_range(i - 1)];
			else
				key = rand_key();
			add_load(SLOT_W'(i), key, rand_weight());
		end
		sent  = TABLE_SLOTS;
		phase = 0;

		while (sent < RANDOM_REQS) begin
			case (phase % 5)
				0: setting = COUNT_W'(TABLE_SLOTS);
				1: setting = '0;
				2: setting = COUNT_W'($urandom_range(TABLE_SLOTS + 1, 127));
				3: setting = 7'd1;
				default: setting = COUNT_W'($urandom_range(2, TABLE_SLOTS - 1));
			endcase
			write_entries(setting);
			burst = (phase % 3 == 2);
			n_eff = (setting > TABLE_SLOTS) ? TABLE_SLOTS : setting;
			phase_reqs = 0;
			while (phase_reqs < 90) begin
				doc_len = ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 20);
				for (int e = 0; e < doc_len; e++) begin
					r = $urandom_range(99);
					if (r < 5) begin
						add_load(SLOT_W'($urandom), rand_key(), rand_weight());
						phase_reqs++;
					end else if (r < 8) begin
						add_other(CMD_EMPTY);
						phase_reqs++;
					end else if (r < 10) begin
						add_other(CMD_UNUSED);
					end
					r = $urandom_range(99);
					if (r < 65 && n_eff > 0)
						key = gen_key[$urandom_range(n_eff - 1)];
					else if (r < 82)
						key = gen_key[$urandom_range(TABLE_SLOTS - 1)];
					else
						key = rand_key();
					add_element(key, e == doc_len - 1);
					phase_reqs++;
				end
				if ($urandom_range(9) == 0) begin
					add_other(CMD_EMPTY);
					phase_reqs++;
				end
			end
			sent += phase_reqs;
			phase++;
		end

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("sparse_key_max_weight_core verification clean");
		else
			$display("sparse_key_max_weight_core verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/skmw_pkg.sv
sv/skmw_match.sv
sv/sparse_key_max_weight_core.sv
tb/sparse_key_max_weight_core_tb.sv
